// ===== rtl/dqpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dqpf_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PORT_W   = 32;
	localparam int unsigned OCC_W    = 5;
	localparam int unsigned COUNT_W  = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_TAIL = 2'd0,
		CMD_PUSH_HEAD = 2'd1,
		CMD_POP_HEAD  = 2'd2,
		CMD_PEEK      = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	// result control handed from the pointer logic to the output side
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    pop;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/dqpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqpf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dqpf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dqpf_ctrl #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire dqpf_pkg::cmd_t              command,
	input  wire logic [IW-1:0]               item,
	output logic                             mem_we,
	output logic [$clog2(DEPTH)-1:0]         mem_waddr,
	output logic                             mem_re,
	output logic [$clog2(DEPTH)-1:0]         mem_raddr,
	output dqpf_pkg::res_t                   res,
	output logic [$clog2(DEPTH+1)-1:0]       fill,
	output logic [dqpf_pkg::COUNT_W-1:0]     cnt_in,
	output logic [dqpf_pkg::COUNT_W-1:0]     cnt_out
);

	import dqpf_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned SW = AW + 1;

	logic [AW-1:0]      head_q, head_d;
	logic [FW-1:0]      fill_q, fill_d;
	logic [COUNT_W-1:0] cnt_in_q, cnt_out_q;
	logic               push_ok, pop_ok;
	status_t            status_d;
	logic [SW-1:0]      tail_sum;
	logic [AW-1:0]      tail_idx, head_dec, head_inc;
	logic               is_full, is_empty, item_zero;
	res_t               res_s1;

	assign is_full   = (fill_q == FW'(DEPTH));
	assign is_empty  = (fill_q == '0);
	assign item_zero = (item == '0);

	// ring arithmetic without a divider: sum stays below twice the depth
	assign tail_sum = SW'(head_q) + SW'(fill_q);
	assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : AW'(head_q - 1'b1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : AW'(head_q + 1'b1);

	always_comb begin
		push_ok   = 1'b0;
		pop_ok    = 1'b0;
		status_d  = ST_OK;
		head_d    = head_q;
		fill_d    = fill_q;
		mem_waddr = tail_idx;
		unique case (command)
			CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
				if (item_zero) begin
					status_d = ST_ZERO;
				end else if (is_full) begin
					status_d = ST_FULL;
				end else begin
					push_ok = 1'b1;
					fill_d  = fill_q + 1'b1;
					if (command == CMD_PUSH_HEAD) begin
						head_d    = head_dec;
						mem_waddr = head_dec;
					end
				end
			end
			CMD_POP_HEAD: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
					head_d = head_inc;
					fill_d = fill_q - 1'b1;
				end
			end
			CMD_PEEK: begin
				status_d = ST_OK;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign mem_we    = accept && push_ok;
	assign mem_re    = accept && pop_ok;
	assign mem_raddr = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			fill_q    <= '0;
			cnt_in_q  <= '0;
			cnt_out_q <= '0;
			res_s1    <= '{valid: 1'b0, status: ST_OK, pop: 1'b0};
		end else begin
			res_s1.valid <= accept;
			if (accept) begin
				head_q        <= head_d;
				fill_q        <= fill_d;
				res_s1.status <= status_d;
				res_s1.pop    <= pop_ok;
				if (push_ok) begin
					cnt_in_q <= cnt_in_q + 1'b1;
				end
				if (pop_ok) begin
					cnt_out_q <= cnt_out_q + 1'b1;
				end
			end
		end
	end

	assign res     = res_s1;
	assign fill    = fill_q;
	assign cnt_in  = cnt_in_q;
	assign cnt_out = cnt_out_q;

endmodule

`default_nettype wire

// ===== rtl/deque_push_both_pop_front_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                            | handshake
// ----------+--------------------------------------------------+---------------------------
// command   | command[1:0], item_in[31:0]                      | start high, busy low
// result    | status[1:0], item_out[31:0], not_empty,          | done strobe, one cycle,
//           | occupancy[4:0], count_in[31:0], count_out[31:0]  | no back pressure
//
// one transaction per clock; every result appears on done in the cycle
// after its command, the delay being the registered read of the slot ram
// busy stays low: a pop that follows a push to the same slot reads after
// the write edge, so no interlock is needed
// reset clears head, fill and both counters at once; the slot ram needs no
// clearing pass since no slot is read before it is written
// the receiver cannot stall, so results are never held back

module deque_push_both_pop_front_top #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned ITEM_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [dqpf_pkg::CMD_W-1:0]     command,
	input  wire logic [dqpf_pkg::PORT_W-1:0]    item_in,
	output logic                                done,
	output logic [dqpf_pkg::STATUS_W-1:0]       status,
	output logic [dqpf_pkg::PORT_W-1:0]         item_out,
	output logic                                not_empty,
	output logic [dqpf_pkg::OCC_W-1:0]          occupancy,
	output logic [dqpf_pkg::COUNT_W-1:0]        count_in,
	output logic [dqpf_pkg::COUNT_W-1:0]        count_out
);

	import dqpf_pkg::*;

	// items live in the low bits of the 32-bit port word
	localparam int unsigned IW = (ITEM_WIDTH > PORT_W) ? PORT_W : ITEM_WIDTH;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);

	logic          accept;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [IW-1:0] item_trim;
	logic [IW-1:0] rdata;
	res_t          res;
	logic [FW-1:0] fill;

	// no stall source inside the block
	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign item_trim = item_in[IW-1:0];

	dqpf_ctrl #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.command   (cmd_t'(command)),
		.item      (item_trim),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res),
		.fill      (fill),
		.cnt_in    (count_in),
		.cnt_out   (count_out)
	);

	// ring of slots, written on a successful push, read at the head on a pop
	dqpf_ram #(
		.WIDTH (IW),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (item_trim),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// result side: fill and counters already hold the post-command values
	assign done      = res.valid;
	assign status    = res.status;
	assign item_out  = res.pop ? PORT_W'(rdata) : '0;
	assign not_empty = (fill != '0);
	assign occupancy = OCC_W'(fill);

	// a result only follows an accepted command
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without accepted command");

	// the queue never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(DEPTH))
		else $error("fill beyond depth");

	// a full refusal is reported only when the ring is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.status == ST_FULL) |-> (fill == FW'(DEPTH)))
		else $error("full status with free slots");

	// a successful pop advances the pop counter by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.pop) |-> (count_out == $past(count_out) + 1'b1))
		else $error("pop counter mismatch");

endmodule

`default_nettype wire
